// File: hw/rtl/dles_pkg.sv
// Shared types and constants for the delta-list event scheduler.
package dles_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_ADD_OK   = 2'd0;
    localparam logic [1:0] KIND_ADD_FULL = 2'd1;
    localparam logic [1:0] KIND_FIRED    = 2'd2;
    localparam logic [1:0] KIND_ADV_DONE = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] fired_tag;
        logic       last;
    } result_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [31:0]      wdelta;
        logic [7:0]       wtag;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;
endpackage

// File: hw/rtl/dles_mem.sv
// Entry store: delta and tag per slot, one write and one registered read port.
module dles_mem (
    input  logic               clk,
    input  dles_pkg::mem_req_t req,
    output logic [31:0]        rdelta,
    output logic [7:0]         rtag
);
    logic [39:0] mem [dles_pkg::QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= {req.wdelta, req.wtag};
        end
        {rdelta, rtag} <= mem[req.raddr];
    end
endmodule

// File: hw/rtl/dles_ctrl.sv
// Sequencer: walks, shifts and updates the entry store for add and advance.
module dles_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_mode,
    input  logic [31:0]        in_delay,
    input  logic [7:0]         in_tag,
    input  logic [15:0]        in_steps,
    output logic               res_valid,
    input  logic               res_ready,
    output dles_pkg::result_t  res,
    output dles_pkg::mem_req_t req,
    input  logic [31:0]        rdelta,
    input  logic [7:0]         rtag
);
    localparam int IW = dles_pkg::IDX_W;
    localparam int CW = dles_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_AWALK, S_ASHIFT, S_AFIX, S_VHEAD, S_VSHIFT, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [31:0] rem_reg, rem_next;
    logic [7:0] tag_reg, tag_next;
    logic rv_reg, rv_next;
    dles_pkg::result_t res_reg, res_next;
    logic [31:0] hdelta_reg, hdelta_next;
    logic [7:0] htag_reg, htag_next;
    logic [CW-1:0] ins_reg;

    assign in_ready  = (state_reg == S_IDLE) && !rv_reg;
    assign res_valid = rv_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next = pos_reg;
        rem_next = rem_reg;
        tag_next = tag_reg;
        rv_next = rv_reg && !res_ready;
        res_next = res_reg;
        hdelta_next = hdelta_reg;
        htag_next = htag_reg;
        req = '0;
        req.raddr = pos_reg[IW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    tag_next = in_tag;
                    pos_next = '0;
                    req.raddr = '0;
                    if (!in_mode)
                    begin
                        rem_next = in_delay;
                        if (count_reg == CW'(dles_pkg::QUEUE_DEPTH))
                        begin
                            res_next = '{dles_pkg::KIND_ADD_FULL, 8'd0, 1'b1};
                            rv_next = 1'b1;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = S_AFIX;
                        end
                        else
                        begin
                            state_next = S_AWALK;
                        end
                    end
                    else
                    begin
                        rem_next = {16'd0, in_steps};
                        state_next = (count_reg == '0) ? S_OUT : S_VHEAD;
                        res_next = '{dles_pkg::KIND_ADV_DONE, 8'd0, 1'b1};
                        if (count_reg == '0)
                        begin
                            rv_next = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            // rdelta is entry[pos]
            S_AWALK:
            begin
                if (rdelta <= rem_reg)
                begin
                    rem_next = rem_reg - rdelta;
                    pos_next = pos_reg + 1'b1;
                    req.raddr = IW'(pos_reg + 1'b1);
                    if (pos_reg + 1'b1 == count_reg)
                    begin
                        state_next = S_AFIX;
                    end
                end
                else
                begin
                    // entry[pos] follows the new one; shift tail up from the end
                    hdelta_next = rdelta - rem_reg;
                    htag_next = rtag;
                    req.raddr = IW'(count_reg - 1'b1);
                    state_next = S_ASHIFT;
                    pos_next = count_reg;
                end
            end
            // pos_reg = destination index; rdelta = entry[pos-1]
            S_ASHIFT:
            begin
                req.we = 1'b1;
                req.waddr = pos_reg[IW-1:0];
                req.wdelta = rdelta;
                req.wtag = rtag;
                req.raddr = IW'(pos_reg - 2'd2);
                pos_next = pos_reg - 1'b1;
                if (pos_reg - 1'b1 == ins_reg)
                begin
                    req.wdelta = hdelta_reg;
                    req.wtag = htag_reg;
                    state_next = S_AFIX;
                end
            end
            S_AFIX:
            begin
                req.we = 1'b1;
                req.waddr = pos_reg[IW-1:0];
                req.wdelta = rem_reg;
                req.wtag = tag_reg;
                count_next = count_reg + 1'b1;
                res_next = '{dles_pkg::KIND_ADD_OK, 8'd0, 1'b1};
                rv_next = 1'b1;
                state_next = S_IDLE;
            end
            // rdelta = head entry[0]
            S_VHEAD:
            begin
                if (rdelta < rem_reg)
                begin
                    rem_next = rem_reg - rdelta;
                    htag_next = rtag;
                    count_next = count_reg - 1'b1;
                    pos_next = CW'(1);
                    req.raddr = IW'(1);
                    if (count_reg == CW'(1))
                        state_next = S_OUT;
                    else
                        state_next = S_VSHIFT;
                end
                else
                begin
                    req.we = 1'b1;
                    req.waddr = '0;
                    req.wdelta = rdelta - rem_reg;
                    req.wtag = rtag;
                    res_next = '{dles_pkg::KIND_ADV_DONE, 8'd0, 1'b1};
                    rv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            // pos_reg = source index; rdelta = entry[pos]
            S_VSHIFT:
            begin
                req.we = 1'b1;
                req.waddr = IW'(pos_reg - 1'b1);
                req.wdelta = rdelta;
                req.wtag = rtag;
                pos_next = pos_reg + 1'b1;
                req.raddr = IW'(pos_reg + 1'b1);
                if (pos_reg == count_reg)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rv_reg || res_ready)
                begin
                    req.raddr = '0;
                    if (htag_reg != 8'd0)
                    begin
                        res_next = '{dles_pkg::KIND_FIRED, htag_reg, 1'b0};
                        rv_next = 1'b1;
                    end
                    htag_next = 8'd0;
                    if (count_reg == '0)
                        state_next = (htag_reg != 8'd0) ? S_OUT : S_IDLE;
                    else
                        state_next = (htag_reg != 8'd0) ? S_OUT : S_VHEAD;
                    if (htag_reg == 8'd0 && count_reg == '0)
                    begin
                        res_next = '{dles_pkg::KIND_ADV_DONE, 8'd0, 1'b1};
                        rv_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rv_reg <= 1'b0;
            ins_reg <= '0;
            pos_reg <= '0;
            rem_reg <= '0;
            tag_reg <= '0;
            res_reg <= '0;
            hdelta_reg <= '0;
            htag_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rv_reg <= rv_next;
            if (state_reg == S_AWALK)
                ins_reg <= pos_reg;
            pos_reg <= (state_reg == S_ASHIFT && state_next == S_AFIX) ? ins_reg : pos_next;
            rem_reg <= rem_next;
            tag_reg <= tag_next;
            res_reg <= res_next;
            hdelta_reg <= hdelta_next;
            htag_reg <= htag_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(dles_pkg::QUEUE_DEPTH))
        else $error("count overflow");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("accept while busy");
    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AFIX) |-> (count_reg < CW'(dles_pkg::QUEUE_DEPTH)))
        else $error("insert into full queue");
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && !res_ready) |=> (rv_reg && $stable(res_reg)))
        else $error("result dropped");
`endif
endmodule

// File: hw/rtl/delta_list_event_scheduler.sv
// Top level of the delta-list event scheduler.
// channel  dir  tdata                                     tuser
// s_axis   in   mode, delay[31:0], tag[7:0], steps[15:0]  -
// m_axis   out  kind[1:0], fired_tag[7:0]                 -   (tlast = last)
// Add: walk to the insertion point, shift later entries up from the end, write the new one;
// walk plus shift covers at most QUEUE_DEPTH entries. Advance: each fire removes the head
// and moves all later entries down; a fire with tag 0 is silent, with no transfer.
// The entry store has a single read port; the sequencer takes one item at a time.
// Reset empties the queue at once. A stalled m_axis holds the sequencer.
module delta_list_event_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // mode, delay, tag, steps, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // kind, fired_tag, zero pad
    output logic        m_axis_tlast
);
    dles_pkg::mem_req_t req;
    dles_pkg::result_t  res;
    logic [31:0] rdelta;
    logic [7:0]  rtag;

    dles_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_mode  (s_axis_tdata[0]),
        .in_delay (s_axis_tdata[32:1]),
        .in_tag   (s_axis_tdata[40:33]),
        .in_steps (s_axis_tdata[56:41]),
        .res_valid(m_axis_tvalid),
        .res_ready(m_axis_tready),
        .res      (res),
        .req      (req),
        .rdelta   (rdelta),
        .rtag     (rtag)
    );

    dles_mem u_mem (
        .clk   (clk),
        .req   (req),
        .rdelta(rdelta),
        .rtag  (rtag)
    );

    assign m_axis_tdata = {6'd0, res.fired_tag, res.kind};
    assign m_axis_tlast = res.last;
endmodule

// File: verif/delta_list_event_scheduler_checker.sv
// Checker for the delta-list event scheduler: timer-queue predictor and result compare.
module delta_list_event_scheduler_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending_count
);
    logic [31:0]        q_delta [dles_pkg::QUEUE_DEPTH];
    logic [7:0]         q_tag [dles_pkg::QUEUE_DEPTH];
    int                 q_len;
    dles_pkg::result_t  expected_results [$];

    task automatic push_result(input logic [1:0] k, input logic [7:0] t, input logic l);
        dles_pkg::result_t r;
        r.kind = k;
        r.fired_tag = t;
        r.last = l;
        expected_results.push_back(r);
    endtask

    task automatic schedule_event(input logic [31:0] delay, input logic [7:0] tg);
        int pos;
        logic [31:0] rest;
        pos = 0;
        rest = delay;
        if (q_len >= dles_pkg::QUEUE_DEPTH)
        begin
            push_result(dles_pkg::KIND_ADD_FULL, 8'd0, 1'b1);
            return;
        end
        while (pos < q_len && q_delta[pos] <= rest)
        begin
            rest -= q_delta[pos];
            pos++;
        end
        for (int i = q_len; i > pos; i--)
        begin
            q_delta[i] = q_delta[i-1];
            q_tag[i] = q_tag[i-1];
        end
        q_delta[pos] = rest;
        q_tag[pos] = tg;
        q_len++;
        if (pos + 1 < q_len)
            q_delta[pos+1] -= rest;
        push_result(dles_pkg::KIND_ADD_OK, 8'd0, 1'b1);
    endtask

    task automatic advance_clock(input logic [15:0] steps);
        logic [31:0] rest;
        logic [7:0] tg;
        rest = {16'd0, steps};
        while (q_len > 0)
        begin
            if (q_delta[0] < rest)
            begin
                tg = q_tag[0];
                rest -= q_delta[0];
                for (int i = 1; i < q_len; i++)
                begin
                    q_delta[i-1] = q_delta[i];
                    q_tag[i-1] = q_tag[i];
                end
                q_len--;
                if (tg != 8'd0)
                    push_result(dles_pkg::KIND_FIRED, tg, 1'b0);
            end
            else
            begin
                q_delta[0] -= rest;
                break;
            end
        end
        push_result(dles_pkg::KIND_ADV_DONE, 8'd0, 1'b1);
    endtask

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        dles_pkg::result_t exp_r;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            q_len <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tdata[0] == 1'b0)
                    schedule_event(s_axis_tdata[32:1], s_axis_tdata[40:33]);
                else
                    advance_clock(s_axis_tdata[56:41]);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected transfer kind=%0d tag=%0d", m_axis_tdata[1:0],
                           m_axis_tdata[9:2]);
                    errs++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (m_axis_tdata[1:0] !== exp_r.kind)
                    begin
                        $error("kind expected %0d actual %0d", exp_r.kind, m_axis_tdata[1:0]);
                        errs++;
                    end
                    if (m_axis_tdata[9:2] !== exp_r.fired_tag)
                    begin
                        $error("fired_tag expected %0d actual %0d", exp_r.fired_tag,
                               m_axis_tdata[9:2]);
                        errs++;
                    end
                    if (m_axis_tlast !== exp_r.last)
                    begin
                        $error("last expected %0d actual %0d", exp_r.last, m_axis_tlast);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end
endmodule

// File: verif/delta_list_event_scheduler_tb.sv
// Testbench top for the delta-list event scheduler: stimulus, handshake pacing, verdict.
module delta_list_event_scheduler_tb;
    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count;
    int          pending_count;
    int          sink_idle_pct = 30;
    int          source_idle_pct = 30;
    bit          hold_sink = 1'b0;

    always #10 clk = ~clk;

    delta_list_event_scheduler uut (.*);

    delta_list_event_scheduler_checker chk (.*);

    always @(posedge clk)
    begin
        if (!rst_n || hold_sink)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic send_item(input logic mode, input logic [31:0] delay,
                             input logic [7:0] tg, input logic [15:0] steps);
        while ($urandom_range(99) < source_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, steps, tg, delay, mode};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic add_event(input logic [31:0] delay, input logic [7:0] tg);
        send_item(MODE_ADD, delay, tg, 16'd0);
    endtask

    task automatic advance(input logic [15:0] steps);
        send_item(MODE_ADVANCE, $urandom, 8'($urandom), steps);
    endtask

    function automatic logic [31:0] pick_delay();
        case ($urandom_range(5))
            0: pick_delay = 32'd0;
            1: pick_delay = $urandom;
            2: pick_delay = 32'hFFFF_FFF0 + $urandom_range(15);
            default: pick_delay = $urandom_range(300);
        endcase
    endfunction

    function automatic logic [15:0] pick_steps();
        case ($urandom_range(5))
            0: pick_steps = 16'd0;
            1: pick_steps = 16'($urandom);
            2: pick_steps = 16'hFFFF;
            default: pick_steps = 16'($urandom_range(120));
        endcase
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        #50000000;
        $display("delta_list_event_scheduler test failed");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed
        advance(16'd5);
        add_event(32'd10, 8'd1);
        add_event(32'd10, 8'd2);
        add_event(32'd5, 8'd0);
        add_event(32'hFFFF_FFFF, 8'hFF);
        add_event(32'd0, 8'hAA);
        advance(16'd0);
        advance(16'd5);
        advance(16'd1);
        advance(16'd5);
        advance(16'd1);
        advance(16'hFFFF);
        for (int i = 0; i < 17; i++)
            add_event(32'(i * 3), 8'h55 ^ i[7:0]);
        wait_drained();
        advance(16'hFFFF);
        // long receiver hold while the sender keeps offering
        fork
            begin
                hold_sink = 1'b1;
                repeat (300) @(posedge clk);
                hold_sink = 1'b0;
            end
            for (int i = 0; i < 20; i++)
                add_event(32'($urandom_range(50)), 8'($urandom));
        join
        wait_drained();
        for (int n = 0; n < 400; n++)
        begin
            if (n == 100)
            begin
                sink_idle_pct = 0;
                source_idle_pct = 0;
            end
            if (n == 160)
            begin
                sink_idle_pct = 30;
                source_idle_pct = 30;
            end
            if ($urandom_range(99) < 60)
                add_event(pick_delay(), ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom));
            else
                advance(pick_steps());
        end
        wait_drained();
        if (fail_count == 0 && pending_count == 0)
            $display("delta_list_event_scheduler test passed");
        else
            $display("delta_list_event_scheduler test failed");
        $finish;
    end
endmodule

// File: delta_list_event_scheduler.f
hw/rtl/dles_pkg.sv
hw/rtl/dles_mem.sv
hw/rtl/dles_ctrl.sv
hw/rtl/delta_list_event_scheduler.sv
verif/delta_list_event_scheduler_checker.sv
verif/delta_list_event_scheduler_tb.sv
